[hw/rtl/tns_pkg.sv]
// Shared types and constants of the tone note sequencer.
`default_nettype none

package tns_pkg;

    // Request codes carried in the req_type field.
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_WRITE  = 3'd1;
    localparam logic [2:0] REQ_SELECT = 3'd2;
    localparam logic [2:0] REQ_START  = 3'd3;
    localparam logic [2:0] REQ_STOP   = 3'd4;

    // Tone actions carried in the tone_action field.
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_SILENCE = 2'd2;

    // Configuration register indexes and widths.
    localparam int         CFG_IDX_W    = 1;
    localparam int         CFG_DATA_W   = 16;
    localparam logic [0:0] CFG_PACE     = 1'b0;
    localparam logic [0:0] CFG_SONG_LEN = 1'b1;

    // Reset value of pace and the lead before note end at which the tone stops.
    localparam logic [15:0] PACE_RESET   = 16'd1000;
    localparam logic [15:0] SILENCE_LEAD = 16'd5;

    // One input item.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [5:0]  note_index;
        logic [15:0] note_tone;
        logic [7:0]  note_octave;
        logic [7:0]  note_length;
        logic [7:0]  note_count;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]  tone_action;
        logic [15:0] tone_value;
        logic [7:0]  tone_octave;
        logic        is_playing;
    } t_out_item;

    // One stored note.
    typedef struct packed {
        logic [15:0] tone;
        logic [7:0]  octave;
        logic [7:0]  length;
        logic [7:0]  count;
    } t_note;

endpackage

`default_nettype wire

[hw/rtl/tone_note_sequencer.sv]
// Top level of the tone note sequencer: note table, timer and duration unit.
//
// Usage: input items arrive on i_in_valid / o_in_ready with an i_in_item payload
// (tick, note write, song select, start, stop). Every item yields exactly one
// result on o_out_valid / i_out_ready carrying the tone action, tone, octave and
// the playing flag after the item. Registers pace and song_length are written
// through i_cfg_we / i_cfg_idx / i_cfg_data by the user only while the block is
// idle; the block itself does not enforce this.
//
// Timing: an item holds the block from its accepting cycle until its result is
// handed over. Most items go from idle straight to the done state, which loads
// the result register once it is free. A tick that loads the next note passes
// through load (pick the note from the table read), divide (pace / length in the
// restoring divider, one quotient bit a cycle), multiply (count multiply with
// saturation) and done (hand the result over). A position past the table or a
// note with length zero skips the divider and the multiply.
//
// Reset (synchronous, active low) stops playback, deselects the song, clears
// timer and position and sets pace to 1000 and song_length to 0. The note table
// keeps its contents. While the receiver stalls, the next result waits and the
// block stays busy, so no further item is accepted until the slot frees.
`default_nettype none

module tone_note_sequencer
    import tns_pkg::*;
#(
    parameter int MAX_NOTES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int         AW        = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam logic [8:0] NOTES_LIM = 9'(MAX_NOTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

    t_state      r_state;
    t_note       r_mem [MAX_NOTES];
    t_note       r_rd_note;
    logic [15:0] r_pace;
    logic [6:0]  r_song_len;
    logic [15:0] r_timer;
    logic [6:0]  r_pos;
    logic        r_playing;
    logic        r_selected;
    t_out_item   r_res;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_quo;
    logic [7:0]  r_rem;
    logic [7:0]  r_divisor;
    logic [7:0]  r_count;
    logic [3:0]  r_cnt;

    logic        w_in_acc;
    logic        w_hand;
    logic [8:0]  w_pos_ext;
    logic [8:0]  w_idx_ext;
    logic        w_pos_ok;
    logic [15:0] w_timer_dec;
    logic [1:0]  w_act;
    logic        w_load;
    logic [8:0]  w_shift;
    logic        w_fits;
    logic [8:0]  w_trial;
    logic [23:0] w_prod;
    logic [15:0] w_dur_sat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_hand      = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Table addressing; out-of-table positions and indexes are caught by compare.
    assign w_pos_ext   = {2'b00, r_pos};
    assign w_idx_ext   = {3'b000, i_in_item.note_index};
    assign w_pos_ok    = (w_pos_ext < NOTES_LIM);
    assign w_timer_dec = r_timer - {15'd0, (r_timer != 16'd0)};

    // Action of an item taken in idle, and whether a tick goes on to load a note.
    always_comb begin
        w_act  = ACT_NONE;
        w_load = 1'b0;
        case (i_in_item.req_type)
            REQ_TICK: begin
                if (r_playing) begin
                    if ((r_pos == r_song_len) && (w_timer_dec == 16'd0)) begin
                        w_act = ACT_SILENCE;
                    end else if (w_timer_dec == SILENCE_LEAD) begin
                        w_act = ACT_SILENCE;
                    end else if (w_timer_dec == 16'd0) begin
                        w_load = 1'b1;
                    end
                end
            end
            REQ_STOP: begin
                w_act = ACT_SILENCE;
            end
            default: ;
        endcase
    end

    // One restoring division step: shift in the next dividend bit and try a subtract.
    assign w_shift = {r_rem, r_quo[15]};
    assign w_fits  = (w_shift >= {1'b0, r_divisor});
    assign w_trial = w_shift - {1'b0, r_divisor};

    // Unit duration times count, saturated to 16 bits.
    assign w_prod    = 24'(r_quo) * 24'(r_count);
    assign w_dur_sat = (w_prod[23:16] != 8'd0) ? 16'hFFFF : w_prod[15:0];

    // Note table: written by note writes, read at the current position every cycle.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_item.req_type == REQ_WRITE) && (w_idx_ext < NOTES_LIM)) begin
            r_mem[w_idx_ext[AW-1:0]] <= t_note'{
                tone:   i_in_item.note_tone,
                octave: i_in_item.note_octave,
                length: i_in_item.note_length,
                count:  i_in_item.note_count
            };
        end
        r_rd_note <= r_mem[w_pos_ext[AW-1:0]];
    end

    // Sequencer, playback state, duration unit and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pace      <= PACE_RESET;
            r_song_len  <= 7'd0;
            r_timer     <= 16'd0;
            r_pos       <= 7'd0;
            r_playing   <= 1'b0;
            r_selected  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= 4'd0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PACE:     r_pace     <= i_cfg_data;
                    CFG_SONG_LEN: r_song_len <= i_cfg_data[6:0];
                    default:      ;
                endcase
            end

            // The output register fills on a hand-over and empties when the receiver takes it.
            if (w_hand) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_res   <= '{tone_action: w_act, tone_value: 16'd0,
                                     tone_octave: 8'd0, is_playing: 1'b0};
                        r_state <= w_load ? S_LOAD : S_DONE;
                        case (i_in_item.req_type)
                            REQ_TICK: begin
                                if (r_playing) begin
                                    r_timer <= w_timer_dec;
                                    if ((r_pos == r_song_len) && (w_timer_dec == 16'd0)) begin
                                        r_playing  <= 1'b0;
                                        r_selected <= 1'b0;
                                    end
                                end
                            end
                            REQ_SELECT: begin
                                r_selected <= 1'b1;
                                r_timer    <= 16'd0;
                                r_pos      <= 7'd0;
                                r_playing  <= 1'b0;
                            end
                            REQ_START: begin
                                if (r_selected) begin
                                    r_pos     <= 7'd0;
                                    r_playing <= 1'b1;
                                    r_timer   <= 16'd0;
                                end
                            end
                            REQ_STOP: begin
                                r_playing  <= 1'b0;
                                r_selected <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end

                // Next note is in the read register: pick the action, set up division.
                S_LOAD: begin
                    r_pos <= r_pos + 7'd1;
                    if (w_pos_ok && (r_rd_note.tone != 16'd0)) begin
                        r_res.tone_action <= ACT_START;
                        r_res.tone_value  <= r_rd_note.tone;
                        r_res.tone_octave <= r_rd_note.octave;
                    end else begin
                        r_res.tone_action <= ACT_SILENCE;
                    end
                    r_quo     <= r_pace;
                    r_rem     <= 8'd0;
                    r_divisor <= r_rd_note.length;
                    r_count   <= r_rd_note.count;
                    r_cnt     <= 4'd15;
                    if (!w_pos_ok || (r_rd_note.length == 8'd0)) begin
                        r_timer <= 16'd0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end

                // One quotient bit a cycle, sixteen quotient bits in all.
                S_DIV: begin
                    r_rem <= w_fits ? w_trial[7:0] : w_shift[7:0];
                    r_quo <= {r_quo[14:0], w_fits};
                    if (r_cnt == 4'd0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end

                S_MUL: begin
                    r_timer <= w_dur_sat;
                    r_state <= S_DONE;
                end

                // Hand the result over once the output register is free.
                S_DONE: begin
                    if (w_hand) begin
                        r_out_item  <= '{tone_action: r_res.tone_action,
                                         tone_value:  r_res.tone_value,
                                         tone_octave: r_res.tone_octave,
                                         is_playing:  r_playing};
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tns_checker.sv]
// Port-level checks of the tone note sequencer and their binding to the top level.
`default_nettype none

module tns_checker
    import tns_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // A result waiting for the receiver holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result pending and the block ready.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("result or busy state survived reset");

    // A tone start carries a real tone and only happens while playing.
    a_start_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.tone_action == ACT_START) |->
            (o_out_item.tone_value != 16'd0) && o_out_item.is_playing)
        else $error("tone start without tone or outside playback");

    // Any other action carries zero tone and octave.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.tone_action != ACT_START) |->
            (o_out_item.tone_value == 16'd0) && (o_out_item.tone_octave == 8'd0))
        else $error("tone fields set on a non-start result");

    // Action is one of the three defined codes.
    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.tone_action == ACT_NONE) ||
            (o_out_item.tone_action == ACT_START) ||
            (o_out_item.tone_action == ACT_SILENCE))
        else $error("undefined tone action");

endmodule

bind tone_note_sequencer tns_checker u_tns_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
